/* hdl/abfha_pkg.sv */
`default_nettype none
package abfha_pkg;

    // Default sizing of the heap, the free table and the block header.
    localparam int DEF_HEAP_BYTES   = 65536;
    localparam int DEF_FREE_ENTRIES = 64;
    localparam int DEF_HEADER_BYTES = 4;

    // Field widths fixed by the interface.
    localparam int ADDR_W  = 16;
    localparam int SIZE_W  = 16;
    localparam int LIMIT_W = 17;
    localparam int KEY_W   = 18;
    localparam int CFG_W   = 17;

    // Request modes.
    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_HEAP_FULL = 2'd1;
    localparam logic [1:0] STAT_TABLE_FULL = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_NULL_ADDRESS = 1'b0;
    localparam logic CFG_HEAP_LIMIT   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR,
        S_REL_RD,
        S_REL_WR,
        S_RESULT
    } t_state;

endpackage
`default_nettype wire

/* hdl/aligned_best_fit_heap_allocator.sv */
// Best-fit heap allocator with aligned payloads. Requests arrive one beat at a
// time and each produces exactly one result beat. An allocate scans the free
// table, one entry a cycle through its single read port; when a filed block is
// reused, the gap is closed and the entries behind it move down one place, each
// read and then written back. A release reads the header memory, then writes
// the free table; a clear or an unused mode goes straight to the result.
// Block headers live in a memory of HEAP_BYTES entries that is never cleared;
// only the header of the first payload address is restored by reset and clear.
// A new request is taken while the previous result still waits at the output.
`default_nettype none
module aligned_best_fit_heap_allocator
    import abfha_pkg::*;
#(
    parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
    parameter int FREE_ENTRIES = DEF_FREE_ENTRIES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_mode,
    input  wire logic [SIZE_W-1:0] i_alloc_size,
    input  wire logic [1:0]        i_align_log2,
    input  wire logic [ADDR_W-1:0] i_block_address,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [ADDR_W-1:0]      o_payload_address,
    output logic                   o_reused,
    output logic [1:0]             o_status
);

    localparam int IW  = $clog2(FREE_ENTRIES);
    localparam int CW  = $clog2(FREE_ENTRIES + 1);
    localparam int HAW = $clog2(HEAP_BYTES);
    localparam int OW  = $clog2(HEADER_BYTES + 8);
    localparam int HW  = SIZE_W + 2 + OW;
    localparam int FW  = KEY_W + ADDR_W;
    localparam logic [17:0] HEAP_END  = 18'(HEAP_BYTES);
    localparam logic [CW-1:0] FE_CNT  = CW'(FREE_ENTRIES);
    localparam logic [2:0]  HDR_M1    = 3'(HEADER_BYTES - 1);

    // Payload offset: header, then padding up to the alignment.
    function automatic logic [OW-1:0] pay_offset(input logic [2:0] blk_lo,
                                                 input logic [1:0] al2);
        logic [3:0] mask;
        logic [3:0] part;
        mask = 4'((4'd1 << al2) - 4'd1);
        part = {1'b0, 3'(blk_lo + HDR_M1)} & mask;
        return OW'(HEADER_BYTES) + OW'(mask) - OW'(part);
    endfunction

    t_state              r_state, n_state;
    logic [LIMIT_W-1:0]  r_top, n_top;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_rv, n_rv;
    logic                r_found, n_found;
    logic [KEY_W-1:0]    r_bkey, n_bkey;
    logic [ADDR_W-1:0]   r_bblk, n_bblk;
    logic [IW-1:0]       r_bidx, n_bidx;
    logic [1:0]          r_mode, n_mode;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [1:0]          r_al2, n_al2;
    logic [ADDR_W-1:0]   r_baddr, n_baddr;
    logic                r_dflt, n_dflt;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic                r_res_reused, n_res_reused;
    logic [1:0]          r_res_status, n_res_status;
    logic                r_ov, n_ov;
    logic [ADDR_W-1:0]   r_o_addr, n_o_addr;
    logic                r_o_reused, n_o_reused;
    logic [1:0]          r_o_status, n_o_status;
    logic [ADDR_W-1:0]   r_null;
    logic [LIMIT_W-1:0]  r_lim;

    logic            ft_we;
    logic [IW-1:0]   ft_waddr, ft_raddr;
    logic [FW-1:0]   ft_wdata, ft_q;
    logic            hd_we;
    logic [HAW-1:0]  hd_waddr;
    logic [HW-1:0]   hd_wdata, hd_q;

    // Free table: {alignment log2, size, block address}.
    abfha_ram #(.WIDTH(FW), .DEPTH(FREE_ENTRIES)) u_free_table (
        .i_clk   (i_clk),
        .i_we    (ft_we),
        .i_waddr (ft_waddr),
        .i_wdata (ft_wdata),
        .i_raddr (ft_raddr),
        .o_rdata (ft_q)
    );

    // Block headers: {size, alignment log2, payload offset}.
    abfha_ram #(.WIDTH(HW), .DEPTH(HEAP_BYTES)) u_hdr_store (
        .i_clk   (i_clk),
        .i_we    (hd_we),
        .i_waddr (hd_waddr),
        .i_wdata (hd_wdata),
        .i_raddr (r_baddr[HAW-1:0]),
        .o_rdata (hd_q)
    );

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_ov;
    assign o_payload_address = r_o_addr;
    assign o_reused          = r_o_reused;
    assign o_status          = r_o_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null <= '0;
            r_lim  <= 17'h10000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NULL_ADDRESS: r_null <= i_cfg_data[ADDR_W-1:0];
                CFG_HEAP_LIMIT:   r_lim  <= i_cfg_data;
                default:          r_lim  <= r_lim;
            endcase
        end
    end

    // Sequencer state and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= LIMIT_W'(HEADER_BYTES);
            r_count <= '0;
            r_dflt  <= 1'b1;
            r_ov    <= 1'b0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_count <= n_count;
            r_dflt  <= n_dflt;
            r_ov    <= n_ov;
            r_rv    <= n_rv;
        end
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_bkey       <= n_bkey;
        r_bblk       <= n_bblk;
        r_bidx       <= n_bidx;
        r_mode       <= n_mode;
        r_size       <= n_size;
        r_al2        <= n_al2;
        r_baddr      <= n_baddr;
        r_res_addr   <= n_res_addr;
        r_res_reused <= n_res_reused;
        r_res_status <= n_res_status;
        r_o_addr     <= n_o_addr;
        r_o_reused   <= n_o_reused;
        r_o_status   <= n_o_status;
    end

    // Next state and memory access.
    always_comb begin
        logic [KEY_W-1:0]   req;
        logic [KEY_W-1:0]   ekey;
        logic [OW-1:0]      off;
        logic [17:0]        padr;
        logic [18:0]        pend;
        logic [LIMIT_W-1:0] lim;
        logic [HW-1:0]      hdr;
        logic [CW-1:0]      nxt;

        n_state      = r_state;
        n_top        = r_top;
        n_count      = r_count;
        n_idx        = r_idx;
        n_rv         = r_rv;
        n_found      = r_found;
        n_bkey       = r_bkey;
        n_bblk       = r_bblk;
        n_bidx       = r_bidx;
        n_mode       = r_mode;
        n_size       = r_size;
        n_al2        = r_al2;
        n_baddr      = r_baddr;
        n_dflt       = r_dflt;
        n_res_addr   = r_res_addr;
        n_res_reused = r_res_reused;
        n_res_status = r_res_status;
        n_o_addr     = r_o_addr;
        n_o_reused   = r_o_reused;
        n_o_status   = r_o_status;
        n_ov         = r_ov && i_out_stall;

        ft_we    = 1'b0;
        ft_waddr = r_idx[IW-1:0];
        ft_wdata = ft_q;
        ft_raddr = r_idx[IW-1:0];
        hd_we    = 1'b0;
        hd_wdata = '0;

        req  = {r_al2, r_size};
        ekey = ft_q[FW-1:ADDR_W];
        nxt  = r_idx + CW'(1);
        off  = '0;
        padr = '0;
        pend = '0;
        lim  = (r_lim < LIMIT_W'(HEAP_BYTES)) ? r_lim : LIMIT_W'(HEAP_BYTES);
        hdr  = (r_dflt && r_baddr == ADDR_W'(HEADER_BYTES))
             ? {SIZE_W'(0), 2'd0, OW'(HEADER_BYTES)} : hd_q;
        hd_waddr = padr[HAW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode       = i_mode;
                    n_size       = i_alloc_size;
                    n_al2        = i_align_log2;
                    n_baddr      = i_block_address;
                    n_idx        = '0;
                    n_rv         = 1'b0;
                    n_found      = 1'b0;
                    n_res_addr   = r_null;
                    n_res_reused = 1'b0;
                    n_res_status = STAT_OK;
                    n_state      = S_RESULT;
                    case (i_mode)
                        MODE_ALLOC: n_state = S_SCAN;
                        MODE_RELEASE: begin
                            if (i_block_address != r_null &&
                                {1'b0, i_block_address} < 17'(HEAP_BYTES)) begin
                                n_state = S_REL_RD;
                            end
                        end
                        MODE_CLEAR: begin
                            n_top   = LIMIT_W'(HEADER_BYTES);
                            n_count = '0;
                            n_dflt  = 1'b1;
                        end
                        default: n_state = S_RESULT;
                    endcase
                end
            end
            S_SCAN: begin
                // Pick the smallest fitting key; the earliest wins a tie.
                if (r_rv && ekey >= req && (!r_found || ekey < r_bkey)) begin
                    n_found = 1'b1;
                    n_bkey  = ekey;
                    n_bblk  = ft_q[ADDR_W-1:0];
                    n_bidx  = r_idx[IW-1:0] - IW'(1);
                end
                if (r_idx < r_count) begin
                    n_idx = nxt;
                    n_rv  = 1'b1;
                end else begin
                    n_rv = 1'b0;
                    if (!r_rv) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (r_found && r_bkey[KEY_W-1:SIZE_W] == r_al2) begin
                    off  = pay_offset(r_bblk[2:0], r_al2);
                    padr = {2'b00, 16'(r_bblk + ADDR_W'(off))};
                    hd_waddr = padr[HAW-1:0];
                    hd_wdata = {r_size, r_al2, off};
                    if (padr < HEAP_END) begin
                        hd_we = 1'b1;
                        if (padr == 18'(HEADER_BYTES)) begin
                            n_dflt = 1'b0;
                        end
                    end
                    n_res_addr   = padr[ADDR_W-1:0];
                    n_res_reused = 1'b1;
                    n_idx        = CW'(r_bidx);
                    n_state      = S_SH_RD;
                end else begin
                    off  = pay_offset(r_top[2:0], r_al2);
                    padr = {1'b0, r_top} + 18'(off);
                    pend = {1'b0, padr} + 19'(r_size);
                    hd_waddr = padr[HAW-1:0];
                    hd_wdata = {r_size, r_al2, off};
                    if (pend > 19'(lim) || padr >= HEAP_END || padr > 18'hFFFF) begin
                        n_res_status = STAT_HEAP_FULL;
                    end else begin
                        n_top      = pend[LIMIT_W-1:0];
                        hd_we      = 1'b1;
                        n_res_addr = padr[ADDR_W-1:0];
                        if (padr == 18'(HEADER_BYTES)) begin
                            n_dflt = 1'b0;
                        end
                    end
                    n_state = S_RESULT;
                end
            end
            S_SH_RD: begin
                // Close the gap left by the reused entry.
                if (nxt < r_count) begin
                    ft_raddr = nxt[IW-1:0];
                    n_state  = S_SH_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESULT;
                end
            end
            S_SH_WR: begin
                ft_we    = 1'b1;
                ft_waddr = r_idx[IW-1:0];
                ft_wdata = ft_q;
                n_idx    = nxt;
                n_state  = S_SH_RD;
            end
            S_REL_RD: begin
                n_state = S_REL_WR;
            end
            S_REL_WR: begin
                if (r_count >= FE_CNT) begin
                    n_res_status = STAT_TABLE_FULL;
                end else begin
                    ft_we    = 1'b1;
                    ft_waddr = r_count[IW-1:0];
                    ft_wdata = {hdr[OW+:2], hdr[HW-1-:SIZE_W],
                                16'(r_baddr - ADDR_W'(hdr[OW-1:0]))};
                    n_count  = r_count + CW'(1);
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov       = 1'b1;
                    n_o_addr   = r_res_addr;
                    n_o_reused = r_res_reused;
                    n_o_status = r_res_status;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The fill count never passes the table depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FE_CNT)
        else $error("free table count beyond depth");

    // The bump pointer stays inside the heap.
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top >= LIMIT_W'(HEADER_BYTES) && r_top <= LIMIT_W'(HEAP_BYTES))
        else $error("heap top out of range");

    // The scan pointer never runs past the filled entries.
    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_idx <= r_count)
        else $error("scan index past fill count");

    // A chosen entry always fits the request.
    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_found) |-> r_bkey >= {r_al2, r_size})
        else $error("best entry smaller than request");

    // A reuse removes exactly one entry from the table.
    a_reuse_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_RD && r_idx + CW'(1) >= r_count) |=> r_count == $past(r_count) - CW'(1))
        else $error("reuse did not shrink the table");

endmodule
`default_nettype wire

/* hdl/abfha_ram.sv */
`default_nettype none
module abfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* dv/tb_aligned_best_fit_heap_allocator.sv */
`default_nettype none
module tb_aligned_best_fit_heap_allocator;
    import abfha_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         HEAP_SZ      = DEF_HEAP_BYTES;
    localparam int         TABLE_SZ     = DEF_FREE_ENTRIES;
    localparam int         HDR_SZ       = DEF_HEADER_BYTES;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         PHASES       = 6;
    localparam int         PHASE_ITEMS  = 330;
    localparam int         DRAIN_CYCLES = 300;
    localparam int         HOLD_CYCLES  = 500;
    localparam int         CYCLE_LIMIT  = 3000000;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              reused;
        logic [1:0]        status;
    } heap_result_t;

    typedef struct {
        logic [1:0]        mode;
        logic [SIZE_W-1:0] size;
        logic [1:0]        alog;
        logic [ADDR_W-1:0] baddr;
        bit                typed;
        logic [ADDR_W-1:0] e_addr;
        logic              e_reused;
        logic [1:0]        e_status;
    } heap_req_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_mode;
    logic [SIZE_W-1:0] i_alloc_size;
    logic [1:0]        i_align_log2;
    logic [ADDR_W-1:0] i_block_address;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [ADDR_W-1:0] o_payload_address;
    logic              o_reused;
    logic [1:0]        o_status;

    aligned_best_fit_heap_allocator u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_alloc_size     (i_alloc_size),
        .i_align_log2     (i_align_log2),
        .i_block_address  (i_block_address),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_payload_address(o_payload_address),
        .o_reused         (o_reused),
        .o_status         (o_status)
    );

    // Shadow copy of the allocator state.
    int unsigned  null_addr_m;
    int unsigned  heap_limit_m;
    int unsigned  heap_top_m;
    int unsigned  free_key[$];
    int unsigned  free_blk[$];
    int unsigned  hdr_size[int];
    int unsigned  hdr_align[int];
    int unsigned  hdr_off[int];
    int unsigned  hdr_addrs[$];

    heap_result_t pending_results[$];
    bit           failed;
    bit           stim_done;
    int unsigned  results_seen;
    int unsigned  cycle_count;

    // Directed requests: typed rows are obvious from reset state, others use the predictor.
    heap_req_row_t directed_rows[21] = '{
        '{MODE_ALLOC,   16'd0,     2'd0, 16'd0,    1, 16'd8, 1'b0, STAT_OK},
        '{MODE_ALLOC,   16'hFFFF,  2'd3, 16'hFFFF, 1, 16'd0, 1'b0, STAT_HEAP_FULL},
        '{MODE_RELEASE, 16'hFFFF,  2'd3, 16'd0,    1, 16'd0, 1'b0, STAT_OK},
        '{MODE_RELEASE, 16'd0,     2'd0, 16'd8,    1, 16'd0, 1'b0, STAT_OK},
        '{MODE_ALLOC,   16'd0,     2'd0, 16'hFFFF, 1, 16'd8, 1'b1, STAT_OK},
        '{MODE_UNUSED,  16'hFFFF,  2'd3, 16'hFFFF, 1, 16'd0, 1'b0, STAT_OK},
        '{MODE_CLEAR,   16'hFFFF,  2'd3, 16'hFFFF, 1, 16'd0, 1'b0, STAT_OK},
        '{MODE_ALLOC,   16'd100,   2'd3, 16'd0,    0, 16'd0, 1'b0, STAT_OK},
        '{MODE_ALLOC,   16'd7,     2'd1, 16'd0,    0, 16'd0, 1'b0, STAT_OK},
        '{MODE_ALLOC,   16'd3,     2'd2, 16'd0,    0, 16'd0, 1'b0, STAT_OK},
        '{MODE_RELEASE, 16'd0,     2'd0, 16'd8,    0, 16'd0, 1'b0, STAT_OK},
        '{MODE_RELEASE, 16'd0,     2'd0, 16'd112,  0, 16'd0, 1'b0, STAT_OK},
        '{MODE_RELEASE, 16'd0,     2'd0, 16'd124,  0, 16'd0, 1'b0, STAT_OK},
        '{MODE_RELEASE, 16'd0,     2'd0, 16'd4,    0, 16'd0, 1'b0, STAT_OK},
        '{MODE_ALLOC,   16'd50,    2'd3, 16'd0,    0, 16'd0, 1'b0, STAT_OK},
        '{MODE_ALLOC,   16'd200,   2'd3, 16'd0,    0, 16'd0, 1'b0, STAT_OK},
        '{MODE_ALLOC,   16'd0,     2'd0, 16'd0,    0, 16'd0, 1'b0, STAT_OK},
        '{MODE_ALLOC,   16'hFFFF,  2'd0, 16'd0,    0, 16'd0, 1'b0, STAT_OK},
        '{MODE_ALLOC,   16'd1,     2'd1, 16'd0,    0, 16'd0, 1'b0, STAT_OK},
        '{MODE_RELEASE, 16'd0,     2'd0, 16'd124,  0, 16'd0, 1'b0, STAT_OK},
        '{MODE_RELEASE, 16'd0,     2'd0, 16'd124,  0, 16'd0, 1'b0, STAT_OK}
    };

    // Clock and cycle watchdog.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Bytes from a block start to its aligned payload, header included.
    function automatic int unsigned payload_gap(int unsigned blk, int unsigned align);
        int unsigned mask;
        mask = align - 1;
        return HDR_SZ + mask - ((blk + HDR_SZ - 1) & mask);
    endfunction

    function automatic void write_header(int unsigned adr, int unsigned size,
                                         int unsigned align, int unsigned off);
        if (adr < HEAP_SZ) begin
            if (!hdr_size.exists(adr))
                hdr_addrs.push_back(adr);
            hdr_size[adr]  = size;
            hdr_align[adr] = align;
            hdr_off[adr]   = off;
        end
    endfunction

    function automatic void clear_heap();
        heap_top_m = HDR_SZ;
        free_key.delete();
        free_blk.delete();
        write_header(HDR_SZ, 0, 1, HDR_SZ);
    endfunction

    // Work out the result of one request and advance the shadow state.
    function automatic heap_result_t predict_heap_op(logic [1:0] mode, logic [SIZE_W-1:0] size,
                                                     logic [1:0] alog, logic [ADDR_W-1:0] baddr);
        heap_result_t r;
        int unsigned  align, req, best, blk, off, adr, fin, lim;
        bit           found;
        align    = 1 << alog;
        r.addr   = null_addr_m[ADDR_W-1:0];
        r.reused = 1'b0;
        r.status = STAT_OK;
        found    = 0;
        best     = 0;
        if (mode == MODE_ALLOC) begin
            req = (align << 16) | size;
            for (int i = 0; i < free_key.size(); i++) begin
                if (free_key[i] >= req && (!found || free_key[i] < free_key[best])) begin
                    best  = i;
                    found = 1;
                end
            end
            if (found && (free_key[best] >> 16) == align) begin
                blk = free_blk[best];
                off = payload_gap(blk, align);
                adr = (blk + off) & 16'hFFFF;
                free_key.delete(best);
                free_blk.delete(best);
                write_header(adr, size, align, off);
                r.addr   = adr[ADDR_W-1:0];
                r.reused = 1'b1;
            end else begin
                lim = (heap_limit_m < HEAP_SZ) ? heap_limit_m : HEAP_SZ;
                blk = heap_top_m;
                off = payload_gap(blk, align);
                adr = blk + off;
                fin = adr + size;
                if (fin > lim || adr >= HEAP_SZ || adr > 16'hFFFF) begin
                    r.status = STAT_HEAP_FULL;
                end else begin
                    heap_top_m = fin;
                    write_header(adr, size, align, off);
                    r.addr = adr[ADDR_W-1:0];
                end
            end
        end else if (mode == MODE_RELEASE) begin
            if (baddr != null_addr_m && baddr < HEAP_SZ) begin
                if (free_key.size() >= TABLE_SZ) begin
                    r.status = STAT_TABLE_FULL;
                end else begin
                    free_key.push_back((hdr_align[baddr] << 16) | hdr_size[baddr]);
                    free_blk.push_back((baddr - hdr_off[baddr]) & 16'hFFFF);
                end
            end
        end else if (mode == MODE_CLEAR) begin
            clear_heap();
        end
        return r;
    endfunction

    // Offer one request beat and hold it until accepted; returns at a falling edge.
    task automatic send_request(heap_req_row_t row);
        heap_result_t r;
        i_mode          = row.mode;
        i_alloc_size    = row.size;
        i_align_log2    = row.alog;
        i_block_address = row.baddr;
        i_in_valid      = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
            @(negedge i_clk);
        end
        r = predict_heap_op(row.mode, row.size, row.alog, row.baddr);
        if (row.typed) begin
            r.addr   = row.e_addr;
            r.reused = row.e_reused;
            r.status = row.e_status;
        end
        pending_results.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_NULL_ADDRESS)
            null_addr_m = val[ADDR_W-1:0];
        else
            heap_limit_m = val;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Random request; releases target an address whose header has been written, or at times the null address.
    function automatic heap_req_row_t random_request(int unsigned rel_pct, int unsigned clr_pct);
        heap_req_row_t row;
        int unsigned   pick;
        row.typed = 0;
        row.alog  = $urandom_range(0, 3);
        row.baddr = $urandom;
        pick      = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       row.size = $urandom;
            1, 2:    row.size = $urandom_range(0, 1024);
            default: row.size = $urandom_range(0, 40);
        endcase
        if (pick < clr_pct) begin
            row.mode = MODE_CLEAR;
        end else if (pick < clr_pct + 1) begin
            row.mode = MODE_UNUSED;
        end else if (pick < clr_pct + 1 + rel_pct) begin
            row.mode = MODE_RELEASE;
            if ($urandom_range(0, 19) == 0)
                row.baddr = null_addr_m[ADDR_W-1:0];
            else
                row.baddr = hdr_addrs[$urandom_range(0, hdr_addrs.size() - 1)];
        end else begin
            row.mode = MODE_ALLOC;
        end
        return row;
    endfunction

    // Request side: reset, directed rows, then phases of random requests.
    initial begin
        heap_req_row_t row;
        int unsigned   burst_left;
        int unsigned   rel_pct;
        int unsigned   clr_pct;
        bit            no_gaps;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_NULL_ADDRESS;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_mode          = MODE_ALLOC;
        i_alloc_size    = '0;
        i_align_log2    = '0;
        i_block_address = '0;
        failed          = 0;
        stim_done       = 0;
        results_seen    = 0;
        cycle_count     = 0;
        null_addr_m     = 0;
        heap_limit_m    = 65536;
        clear_heap();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i]);
        i_in_valid = 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin
                    write_reg(CFG_NULL_ADDRESS, 17'd0);
                    write_reg(CFG_HEAP_LIMIT, 17'd65536);
                end
                1: begin
                    write_reg(CFG_NULL_ADDRESS, 17'hFFFF);
                    write_reg(CFG_HEAP_LIMIT, 17'd4);
                end
                2: begin
                    // Null address lands on the first payload after a clear.
                    write_reg(CFG_NULL_ADDRESS, 17'd8);
                    write_reg(CFG_HEAP_LIMIT, 17'd600);
                end
                3: begin
                    write_reg(CFG_NULL_ADDRESS, $urandom_range(0, 65535));
                    write_reg(CFG_HEAP_LIMIT, $urandom_range(4, 65536));
                end
                4: begin
                    write_reg(CFG_NULL_ADDRESS, 17'd0);
                    write_reg(CFG_HEAP_LIMIT, 17'h1FFFF);
                end
                default: begin
                    write_reg(CFG_NULL_ADDRESS, $urandom_range(0, 65535));
                    write_reg(CFG_HEAP_LIMIT, $urandom_range(2000, 65536));
                end
            endcase
            // Phase 2 opens with a clear so the coinciding address shows up.
            rel_pct    = (p == 4) ? 70 : 40;
            clr_pct    = (p == 2) ? 6 : 2;
            no_gaps    = (p % 3 == 2);
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    if (!no_gaps) begin
                        i_in_valid = 1'b0;
                        repeat ($urandom_range(0, 12)) @(negedge i_clk);
                    end
                end
                row = random_request(rel_pct, clr_pct);
                if (p == 2 && n == 0)
                    row.mode = MODE_CLEAR;
                send_request(row);
                burst_left--;
            end
            i_in_valid = 1'b0;
        end
        stim_done = 1;
    end

    // Result side: stall pattern that changes style, plus one long hold-off.
    initial begin
        int unsigned hold_left;
        int unsigned style;
        int unsigned style_left;
        bit          held;
        i_out_stall = 1'b0;
        hold_left   = 0;
        style       = 0;
        style_left  = 0;
        held        = 0;
        forever begin
            @(negedge i_clk);
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(50, 300);
            end
            style_left--;
            if (!held && results_seen >= 40) begin
                held      = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else begin
                case (style)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = ($urandom_range(0, 9) < 3);
                    2:       i_out_stall = (cycle_count % 5 < 2);
                    default: i_out_stall = ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin
        heap_result_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen = results_seen + 1;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result beat: addr %h reused %b status %0d", $time,
                         o_payload_address, o_reused, o_status);
                failed = 1;
            end else begin
                e = pending_results.pop_front();
                if (o_payload_address !== e.addr) begin
                    $display("%0t payload_address expected %h actual %h", $time, e.addr,
                             o_payload_address);
                    failed = 1;
                end
                if (o_reused !== e.reused) begin
                    $display("%0t reused expected %b actual %b", $time, e.reused, o_reused);
                    failed = 1;
                end
                if (o_status !== e.status) begin
                    $display("%0t status expected %0d actual %0d", $time, e.status, o_status);
                    failed = 1;
                end
            end
        end
    end

    // Drain, let the block settle, then report.
    initial begin
        wait (stim_done);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

/* aligned_best_fit_heap_allocator.f */
hdl/abfha_pkg.sv
hdl/abfha_ram.sv
hdl/aligned_best_fit_heap_allocator.sv
dv/tb_aligned_best_fit_heap_allocator.sv
